>>> rtl/srv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_pkg
// Shared types, constants and functions for the stored record validator.
// ----------------------------------------------------------------------------
package srv_pkg;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned LEN_W      = 9;

    localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd2;

    localparam logic [31:0]      MAGIC_RESET   = 32'h4E4F_5346;
    localparam logic [31:0]      VERSION_RESET = 32'd60;
    localparam logic [LEN_W-1:0] LENGTH_RESET  = 9'd256;
    localparam logic [LEN_W-1:0] LENGTH_MIN    = 9'd8;
    localparam int unsigned      LENGTH_LIMIT  = 508;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef enum logic [1:0] {
        CAUSE_OK          = 2'd0,
        CAUSE_BAD_MAGIC   = 2'd1,
        CAUSE_BAD_VERSION = 2'd2,
        CAUSE_BAD_CRC     = 2'd3
    } fail_cause_t;

    // Configuration as seen by the checker; length is already clamped.
    typedef struct packed {
        logic [31:0]      magic;
        logic [31:0]      version;
        logic [LEN_W-1:0] length;
    } cfg_t;

    typedef struct packed {
        logic        ok;
        fail_cause_t cause;
    } verdict_t;

    // One byte through the reflected CRC-32, eight shift steps unrolled.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    // Little-endian byte lane of a 32-bit word.
    function automatic logic [7:0] byte_lane(input logic [31:0] word,
                                             input logic [1:0]  idx);
        logic [7:0] lane;
        case (idx)
            2'd0:    lane = word[7:0];
            2'd1:    lane = word[15:8];
            2'd2:    lane = word[23:16];
            default: lane = word[31:24];
        endcase
        return lane;
    endfunction

endpackage

>>> rtl/srv_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_cfg_regs
// Configuration registers with the covered length clamped to its legal range.
// ----------------------------------------------------------------------------
module srv_cfg_regs #(
    parameter int MAX_RECORD_BYTES = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srv_pkg::CFG_DATA_W-1:0] cfg_data,
    output srv_pkg::cfg_t                 cfg
);
    import srv_pkg::*;

    localparam int LEN_CAP_INT = (MAX_RECORD_BYTES - 4 > LENGTH_LIMIT) ?
                                 LENGTH_LIMIT : MAX_RECORD_BYTES - 4;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

    logic [31:0]      magic_reg;
    logic [31:0]      version_reg;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= MAGIC_RESET;
            version_reg <= VERSION_RESET;
            length_reg  <= LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAGIC)
            begin
                magic_reg <= cfg_data;
            end
            if (cfg_index == REG_VERSION)
            begin
                version_reg <= cfg_data;
            end
            if (cfg_index == REG_LENGTH)
            begin
                length_reg <= cfg_data[LEN_W-1:0];
            end
        end
    end

    always_comb
    begin
        length_eff = length_reg;
        if (length_eff < LENGTH_MIN)
        begin
            length_eff = LENGTH_MIN;
        end
        if (length_eff > LEN_CAP)
        begin
            length_eff = LEN_CAP;
        end
    end

    assign cfg.magic   = magic_reg;
    assign cfg.version = version_reg;
    assign cfg.length  = length_eff;

endmodule

>>> rtl/srv_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_check
// Record state and per-byte checks: magic, version and running CRC-32.
// ----------------------------------------------------------------------------
module srv_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_present,
    input  logic                take,
    input  logic [7:0]          item_byte,
    input  logic                item_start,
    input  srv_pkg::cfg_t       cfg,
    output logic                verdict_fire,
    output srv_pkg::verdict_t   verdict
);
    import srv_pkg::*;

    logic [LEN_W-1:0] pos_reg,   pos_next;
    logic [31:0]      crc_reg,   crc_next;
    logic             magic_bad_reg,   magic_bad_next;
    logic             version_bad_reg, version_bad_next;
    logic             crc_bad_reg,     crc_bad_next;
    logic             active_reg,      active_next;

    logic [LEN_W-1:0] pos;
    logic [31:0]      crc_cur;
    logic             magic_bad, version_bad, crc_bad, active;
    logic [LEN_W:0]   pos_ext, len_ext, crc_offset;
    logic             done;

    always_comb
    begin
        // A start flag restarts every check with this byte as byte 0.
        pos         = item_start ? '0 : pos_reg;
        crc_cur     = item_start ? CRC_INIT : crc_reg;
        magic_bad   = item_start ? 1'b0 : magic_bad_reg;
        version_bad = item_start ? 1'b0 : version_bad_reg;
        crc_bad     = item_start ? 1'b0 : crc_bad_reg;
        active      = item_start | active_reg;

        pos_ext    = {1'b0, pos};
        len_ext    = {1'b0, cfg.length};
        crc_offset = pos_ext - len_ext;

        if (pos_ext < 10'd4)
        begin
            if (byte_lane(cfg.magic, pos[1:0]) != item_byte)
            begin
                magic_bad = 1'b1;
            end
        end
        else if (pos_ext < 10'd8)
        begin
            if (byte_lane(cfg.version, pos[1:0]) != item_byte)
            begin
                version_bad = 1'b1;
            end
        end

        crc_next = crc_cur;
        if (pos_ext < len_ext)
        begin
            crc_next = crc_byte(crc_cur, item_byte);
        end
        else if (pos_ext < len_ext + 10'd4)
        begin
            if (byte_lane(~crc_cur, crc_offset[1:0]) != item_byte)
            begin
                crc_bad = 1'b1;
            end
        end

        done = active && (pos_ext >= len_ext + 10'd3);

        pos_next         = done ? '0 : pos + 9'd1;
        active_next      = active && !done;
        magic_bad_next   = magic_bad;
        version_bad_next = version_bad;
        crc_bad_next     = crc_bad;

        if (magic_bad)
        begin
            verdict.cause = CAUSE_BAD_MAGIC;
        end
        else if (version_bad)
        begin
            verdict.cause = CAUSE_BAD_VERSION;
        end
        else if (crc_bad)
        begin
            verdict.cause = CAUSE_BAD_CRC;
        end
        else
        begin
            verdict.cause = CAUSE_OK;
        end
        verdict.ok   = (verdict.cause == CAUSE_OK);
        verdict_fire = item_present && done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            crc_reg         <= CRC_INIT;
            magic_bad_reg   <= 1'b0;
            version_bad_reg <= 1'b0;
            crc_bad_reg     <= 1'b0;
            active_reg      <= 1'b0;
        end
        else if (take && active)
        begin
            pos_reg         <= pos_next;
            crc_reg         <= crc_next;
            magic_bad_reg   <= magic_bad_next;
            version_bad_reg <= version_bad_next;
            crc_bad_reg     <= crc_bad_next;
            active_reg      <= active_next;
        end
    end

endmodule

>>> rtl/stored_record_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stored_record_validator
// Checks a stored settings record byte by byte: magic, version and CRC-32.
// ----------------------------------------------------------------------------
// Throughput: one byte per clock cycle unless a byte that gives a verdict
// meets a full, stalled result register; the unrolled CRC-32 byte update is
// combinational between the input register and the state. The last stored
// CRC byte passes the input register, then its verdict the result register.
// Reset (rst_n, asynchronous, active low) loads the configuration reset values
// and closes any open record; there is no clearing pass.
// ----------------------------------------------------------------------------
module stored_record_validator #(
    parameter int MAX_RECORD_BYTES = 512
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // Record byte stream.
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           record_start,

    // Verdict stream.
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic                           record_ok,
    output logic [1:0]                     fail_cause,

    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [srv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srv_pkg::CFG_DATA_W-1:0] cfg_data
);
    import srv_pkg::*;

    cfg_t       cfg;

    // Input register: holds one accepted byte until the checker consumes it.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // Result register: holds a verdict until the consumer takes it.
    logic       out_valid_reg;
    verdict_t   out_verdict_reg;

    logic       verdict_fire;
    verdict_t   verdict;
    logic       advance;

    srv_cfg_regs #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srv_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_present (in_valid_reg),
        .take         (advance),
        .item_byte    (in_byte_reg),
        .item_start   (in_start_reg),
        .cfg          (cfg),
        .verdict_fire (verdict_fire),
        .verdict      (verdict)
    );

    // The held byte moves on unless it produces a verdict while the result
    // register is still full and stalled. Bytes that give no verdict keep
    // flowing even while a verdict waits downstream.
    assign advance    = in_valid_reg &&
                        (!verdict_fire || !out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_byte_reg  <= data_byte;
            in_start_reg <= record_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && verdict_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && verdict_fire)
        begin
            out_verdict_reg <= verdict;
        end
    end

    assign result_valid = out_valid_reg;
    assign record_ok    = out_verdict_reg.ok;
    assign fail_cause   = out_verdict_reg.cause;

endmodule

>>> tb/stored_record_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stored_record_validator_tb
// Self-checking bench for the stored record validator. Settings records are
// built from the current register values, with chosen flaws, and fed one
// byte per beat. A predictor follows every accepted byte and queues the
// verdict it should cause, and each verdict beat is checked against the oldest
// queued verdict. Both sides idle at random, and the receiver also holds off
// long enough to stall the byte stream.
// ----------------------------------------------------------------------------
module stored_record_validator_tb;
    import srv_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int MAX_BYTES     = 512;
    // Margin after the last CRC byte for the input and result registers to settle.
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_BYTES  = 320;
    localparam int LONG_HOLD     = 300;

    // Ways a generated record can be damaged.
    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_CRC,
        FLAW_BODY,
        FLAW_MAGIC_VERSION
    } flaw_e;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    logic [7:0]            data_byte    = 8'd0;
    logic                  record_start = 1'b0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic                  record_ok;
    logic [1:0]            fail_cause;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_MAGIC;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // Predictor copy of the registers and of the record being checked.
    logic [31:0]      cfg_magic;
    logic [31:0]      cfg_version;
    logic [LEN_W-1:0] cfg_length;
    int               rec_pos;
    logic [31:0]      rec_crc;
    bit               rec_open;
    bit               bad_magic;
    bit               bad_version;
    bit               bad_crc;

    verdict_t   verdicts_due[$];
    verdict_t   head_verdict;
    logic [7:0] frame[$];

    int failures        = 0;
    int fed_bytes       = 0;
    int quiet_cycles    = 0;

    // Knobs shared between the test tasks and the receiver process.
    int hold_len  = 0;
    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;

    stored_record_validator #(
        .MAX_RECORD_BYTES (MAX_BYTES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .data_byte    (data_byte),
        .record_start (record_start),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .record_ok    (record_ok),
        .fail_cause   (fail_cause),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Reflected CRC-32, fed one data bit at a time, least significant first.
    // Folding the data bit into the feedback decision is the same as XORing
    // the whole byte in up front.
    function automatic logic [31:0] crc32_feed(input logic [31:0] acc,
                                               input logic [7:0]  b);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ b[i])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    // The covered length the block actually uses: raised to the minimum and
    // capped by both the build-time record size and the fixed ceiling.
    function automatic int clamped_length();
        int len;
        int cap;
        len = cfg_length;
        cap = (MAX_BYTES - 4 < LENGTH_LIMIT) ? MAX_BYTES - 4 : LENGTH_LIMIT;
        if (len < LENGTH_MIN)
            len = LENGTH_MIN;
        if (len > cap)
            len = cap;
        return len;
    endfunction

    function automatic void reset_predictor();
        cfg_magic   = MAGIC_RESET;
        cfg_version = VERSION_RESET;
        cfg_length  = LENGTH_RESET;
        rec_pos     = 0;
        rec_crc     = CRC_INIT;
        rec_open    = 1'b0;
        bad_magic   = 1'b0;
        bad_version = 1'b0;
        bad_crc     = 1'b0;
    endfunction

    // Follows one accepted byte beat and queues a verdict when the record
    // closes. The length register is read on every byte, so a record whose
    // position already lies past the CRC field closes on the next byte.
    function automatic void advance_record(input logic [7:0] b, input logic s);
        int          len;
        int          pos;
        logic [31:0] stored_crc;
        verdict_t    v;
        len = clamped_length();
        if (s)
        begin
            rec_pos     = 0;
            rec_crc     = CRC_INIT;
            bad_magic   = 1'b0;
            bad_version = 1'b0;
            bad_crc     = 1'b0;
            rec_open    = 1'b1;
        end
        if (!rec_open)
            return;

        pos = rec_pos;
        if (pos < 4)
        begin
            if (cfg_magic[8 * pos +: 8] != b)
                bad_magic = 1'b1;
        end
        else if (pos < 8)
        begin
            if (cfg_version[8 * (pos - 4) +: 8] != b)
                bad_version = 1'b1;
        end

        if (pos < len)
            rec_crc = crc32_feed(rec_crc, b);
        else if (pos < len + 4)
        begin
            stored_crc = ~rec_crc;
            if (stored_crc[8 * (pos - len) +: 8] != b)
                bad_crc = 1'b1;
        end

        if (pos < len + 3)
        begin
            rec_pos = pos + 1;
            return;
        end

        // First failing check wins: magic, then version, then CRC.
        if (bad_magic)
            v.cause = CAUSE_BAD_MAGIC;
        else if (bad_version)
            v.cause = CAUSE_BAD_VERSION;
        else if (bad_crc)
            v.cause = CAUSE_BAD_CRC;
        else
            v.cause = CAUSE_OK;
        v.ok = (v.cause == CAUSE_OK);
        verdicts_due.push_back(v);
        rec_open = 1'b0;
        rec_pos  = 0;
    endfunction

    // ------------------------------------------------------------------------
    // Record generation
    // ------------------------------------------------------------------------

    // Builds a record for the current registers: magic, version, random body
    // up to len bytes, then the inverted CRC, all little-endian. Magic and
    // version flaws go in before the CRC is taken so the CRC still matches;
    // body and CRC flaws go in after it.
    function automatic void build_frame(input int len, input flaw_e flaw);
        logic [31:0] acc;
        int          spot;
        frame.delete();
        for (int i = 0; i < len; i++)
        begin
            if (i < 4)
                frame.push_back(cfg_magic[8 * i +: 8]);
            else if (i < 8)
                frame.push_back(cfg_version[8 * (i - 4) +: 8]);
            else
                frame.push_back(8'($urandom));
        end
        if (flaw == FLAW_MAGIC || flaw == FLAW_MAGIC_VERSION)
        begin
            spot = $urandom_range(0, 3);
            frame[spot] = frame[spot] ^ 8'($urandom_range(1, 255));
        end
        if (flaw == FLAW_VERSION || flaw == FLAW_MAGIC_VERSION)
        begin
            spot = $urandom_range(4, 7);
            frame[spot] = frame[spot] ^ 8'($urandom_range(1, 255));
        end

        acc = CRC_INIT;
        for (int i = 0; i < len; i++)
            acc = crc32_feed(acc, frame[i]);
        acc = ~acc;
        for (int i = 0; i < 4; i++)
            frame.push_back(acc[8 * i +: 8]);

        if (flaw == FLAW_BODY && len > 8)
        begin
            spot = $urandom_range(8, len - 1);
            frame[spot] = frame[spot] ^ 8'($urandom_range(1, 255));
        end
        else if (flaw == FLAW_CRC || flaw == FLAW_BODY)
        begin
            spot = $urandom_range(len, len + 3);
            frame[spot] = frame[spot] ^ 8'($urandom_range(1, 255));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Offers one byte beat and returns at the edge that accepts it. Valid is
    // left high so the next call can follow without a bubble; anything that
    // stops sending lowers it first.
    task automatic send_byte(input logic [7:0] b, input logic s);
        if (src_idle && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        item_valid   <= 1'b1;
        data_byte    <= b;
        record_start <= s;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (s || rec_open)
            fed_bytes++;
        advance_record(b, s);
    endtask

    // Sends count bytes of the built record starting at byte first.
    task automatic send_frame(input int first, input int count);
        for (int i = first; i < first + count; i++)
            send_byte(frame[i], i == 0);
    endtask

    task automatic send_record(input flaw_e flaw);
        build_frame(clamped_length(), flaw);
        send_frame(0, frame.size());
    endtask

    // Stops offering bytes, waits for every queued verdict, then lets the
    // pipeline settle so that a byte that gives no verdict is also done.
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_MAGIC:   cfg_magic   = data;
            REG_VERSION: cfg_version = data;
            REG_LENGTH:  cfg_length  = data[LEN_W-1:0];
            default:     ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] magic, input logic [31:0] version,
                             input int length);
        wait_idle();
        write_reg(REG_MAGIC, magic);
        write_reg(REG_VERSION, version);
        write_reg(REG_LENGTH, CFG_DATA_W'(length));
    endtask

    // ------------------------------------------------------------------------
    // Receiver: accepts verdict beats, with random stall bursts and, on
    // request, one long hold-off counted here.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                n = hold_len;
                hold_len = 0;
                result_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Verdict checking: every accepted beat is matched against the oldest
    // verdict the predictor queued.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("verdict beat with none due: record_ok=%0b fail_cause=%0d",
                       record_ok, fail_cause);
                failures++;
            end
            else
            begin
                head_verdict = verdicts_due.pop_front();
                if (record_ok !== head_verdict.ok)
                begin
                    $error("record_ok: expected %0b, actual %0b",
                           head_verdict.ok, record_ok);
                    failures++;
                end
                if (fail_cause !== head_verdict.cause)
                begin
                    $error("fail_cause: expected %0d, actual %0d",
                           head_verdict.cause, fail_cause);
                    failures++;
                end
            end
        end
    end

    // Watchdog: a run that accepts nothing on either side for too long is
    // stuck.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values of all three registers: a well-formed record with the
    // default marker word, version and covered length must pass.
    task automatic test_reset_values();
        send_record(FLAW_NONE);
    endtask

    // Every verdict, with all-zero and all-one marker and version words, and
    // the precedence of magic over version over CRC.
    task automatic test_verdict_causes();
        configure(32'h0000_0000, 32'hFFFF_FFFF, LENGTH_MIN);
        send_record(FLAW_NONE);
        send_record(FLAW_MAGIC);
        send_record(FLAW_VERSION);
        send_record(FLAW_CRC);
        send_record(FLAW_MAGIC_VERSION);
        configure(32'hFFFF_FFFF, 32'h0000_0000, 12);
        send_record(FLAW_NONE);
        send_record(FLAW_BODY);
        // Version and CRC both wrong: version must be reported.
        build_frame(clamped_length(), FLAW_VERSION);
        frame[frame.size() - 1] = ~frame[frame.size() - 1];
        send_frame(0, frame.size());
    endtask

    // Bytes with no record open are dropped, and a start beat in the middle
    // of a record throws the partial record away without a verdict.
    task automatic test_stray_and_restart();
        configure($urandom, $urandom, 16);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'($urandom), 1'b0);
        build_frame(clamped_length(), FLAW_NONE);
        send_frame(0, 9);
        send_frame(0, frame.size());
        // Restart on what would have been the last CRC byte.
        send_frame(0, frame.size() - 1);
        send_record(FLAW_NONE);
        send_byte(8'h5A, 1'b0);
    endtask

    // Covered lengths below the minimum and above the ceiling are clamped;
    // the top register value lands on the ceiling.
    task automatic test_length_limits();
        int lengths[5] = '{0, 7, 8, 9, 511};
        foreach (lengths[i])
        begin
            configure($urandom, $urandom, lengths[i]);
            send_record(lengths[i] == 9 ? FLAW_BODY : FLAW_NONE);
        end
    endtask

    // The length register is read on every byte. Shrinking it under an open
    // record closes the record on the next byte with no CRC compare; growing
    // it moves the CRC field further out.
    task automatic test_length_change();
        configure($urandom, $urandom, 100);
        build_frame(clamped_length(), FLAW_NONE);
        send_frame(0, 30);
        wait_idle();
        write_reg(REG_LENGTH, CFG_DATA_W'(8));
        send_byte(8'($urandom), 1'b0);

        wait_idle();
        build_frame(clamped_length(), FLAW_NONE);
        send_frame(0, 6);
        wait_idle();
        write_reg(REG_LENGTH, CFG_DATA_W'(20));
        // Bytes 0..5 are only marker and version bytes, the same in a
        // record of either length, so this record is well formed.
        build_frame(clamped_length(), FLAW_NONE);
        send_frame(6, frame.size() - 6);
    endtask

    // The receiver holds off for a long stretch while short records keep
    // coming, so a verdict waits in the result register and the byte stream
    // stalls. Then the sender pauses until every verdict is out.
    task automatic test_backpressure();
        configure($urandom, $urandom, LENGTH_MIN);
        src_idle = 1'b0;
        hold_len = LONG_HOLD;
        repeat (12) send_record(FLAW_NONE);
        wait_idle();
        src_idle = 1'b1;
        repeat (3) send_record(flaw_e'($urandom_range(FLAW_NONE, FLAW_MAGIC_VERSION)));
        wait_idle();
    endtask

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Mostly short records; a few below the minimum, some of medium length.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return $urandom_range(0, 7);
        if (r < 20)
            return $urandom_range(33, 120);
        return $urandom_range(8, 32);
    endfunction

    // One random step of the stream: mostly well-formed records with random
    // content, some damaged, truncated, or stray bytes, and now and then a
    // pause until the verdicts are out.
    task automatic random_record();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            send_record(FLAW_NONE);
        else if (r < 85)
            send_record(flaw_e'($urandom_range(FLAW_MAGIC, FLAW_MAGIC_VERSION)));
        else if (r < 92)
        begin
            build_frame(clamped_length(), FLAW_NONE);
            send_frame(0, $urandom_range(1, frame.size() - 1));
        end
        else if (r < 96)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
        else
        begin
            send_record(FLAW_NONE);
            wait_idle();
        end
    endtask

    task automatic test_random_records();
        int records;
        fed_bytes = 0;
        while (fed_bytes < RANDOM_BYTES)
        begin
            configure(pick_word(), pick_word(), pick_length());
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            records = $urandom_range(4, 10);
            for (int i = 0; i < records && fed_bytes < RANDOM_BYTES; i++)
                random_record();
        end
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_quiet_finish();
        configure(pick_word(), pick_word(), $urandom_range(8, 16));
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (6) send_record(flaw_e'($urandom_range(FLAW_NONE, FLAW_MAGIC_VERSION)));
        wait_idle();
    endtask

    initial
    begin
        reset_predictor();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_verdict_causes();
        test_stray_and_restart();
        test_length_limits();
        test_length_change();
        test_backpressure();
        test_random_records();
        test_quiet_finish();

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
